### sv/sbsf_pkg.sv
package sbsf_pkg;

  // Fixed field widths.
  localparam int COEF_BITS      = 24;
  localparam int GAIN_BITS      = 16;
  localparam int GAIN_FRAC_BITS = 15;
  localparam int HEADROOM_BITS  = 8;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_IDX_BITS   = 3;

  // One serial digit of the multiplier operand per cycle.
  localparam int DIG_BITS       = 8;

  // The accumulator carries guard bits for the sum of five products.
  localparam int ACC_GUARD_BITS = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_B0   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_B1   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_B2   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_A1   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_A2   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_GAIN = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MONO_MODE = 3'd6;

  // Control of one multiply-accumulate lane for one cycle.
  typedef struct packed {
    logic step;   // consume one digit of the serial operand
    logic first;  // top (signed) digit; starts a new product
    logic last;   // bottom digit; the product is complete after this step
    logic sub;    // the product is subtracted from the accumulator
    logic clr;    // clear the accumulator
  } mac_ctl_t;

endpackage

### sv/stereo_biquad_shelf_filter_top.sv
// Stereo direct-form-1 biquad with a mono mode.
// Input channel: in_valid / in_stall with one stereo sample pair per
// transaction. Result channel: out_valid / out_stall with one filtered pair
// per transaction. Coefficients, clip gain and mono mode are written through
// cfg_we / cfg_index / cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce. Each channel has
// its own digit-serial multiply-accumulate lane. The five taps are done one
// after the other, ND = OPW / 8 digits each, where OPW is the serial operand
// width rounded up to whole 8-bit digits (3 digits at 16-bit samples). Both
// channels run side by side. In mono the clip gain multiply reuses the left
// lane. The block takes no new pair until the last result is loaded into the
// output register; a new transaction is accepted in the cycle after the load.
// The result sits in an output register, so the next pair is accepted while
// the receiver stalls; that pair's result waits in the last step until the
// output register is free.
// Reset clears all filter history, loads unity b0 and unity clip gain, zeroes
// the other coefficients, selects stereo and drops any pending result.
module stereo_biquad_shelf_filter_top import sbsf_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_right_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  // Derived widths.
  localparam int FB_BITS = SAMPLE_BITS + HEADROOM_BITS;
  localparam int CW      = (COEF_BITS > COEF_FRAC_BITS + 2) ? COEF_BITS : COEF_FRAC_BITS + 2;
  localparam int PARW    = (CW > FB_BITS) ? CW : FB_BITS;
  localparam int SERW    = (FB_BITS > GAIN_BITS + 1) ? FB_BITS : GAIN_BITS + 1;
  localparam int OPW     = ((SERW + DIG_BITS - 1) / DIG_BITS) * DIG_BITS;
  localparam int ND      = OPW / DIG_BITS;
  localparam int DCW     = (ND > 1) ? $clog2(ND) : 1;
  localparam int ACW     = PARW + OPW + ACC_GUARD_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_MFL  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_GAIN = 3'd4;
  localparam logic [2:0] S_GFL  = 3'd5;
  localparam logic [2:0] S_GRND = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  // Tap order within one filter pass.
  localparam logic [2:0] TAP_B0 = 3'd0;
  localparam logic [2:0] TAP_B1 = 3'd1;
  localparam logic [2:0] TAP_B2 = 3'd2;
  localparam logic [2:0] TAP_A1 = 3'd3;
  localparam logic [2:0] TAP_A2 = 3'd4;

  // Rounding and saturation constants.
  localparam logic signed [ACW-1:0] HALF_C = ACW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACW-1:0] HALF_G = ACW'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic signed [ACW-1:0] FB_HI =
    {{(ACW-FB_BITS+1){1'b0}}, {(FB_BITS-1){1'b1}}};
  localparam logic signed [ACW-1:0] FB_LO =
    {{(ACW-FB_BITS+1){1'b1}}, {(FB_BITS-1){1'b0}}};
  localparam logic signed [ACW-1:0] SB_HI =
    {{(ACW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACW-1:0] SB_LO =
    {{(ACW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [FB_BITS-1:0] SBF_HI =
    {{(HEADROOM_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [FB_BITS-1:0] SBF_LO =
    {{(HEADROOM_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration registers.
  logic signed [CW-1:0] coef_b0_r;
  logic signed [CW-1:0] coef_b1_r;
  logic signed [CW-1:0] coef_b2_r;
  logic signed [CW-1:0] coef_a1_r;
  logic signed [CW-1:0] coef_a2_r;
  logic [GAIN_BITS-1:0] clip_gain_r;
  logic                 mono_r;

  // Sequencer.
  logic [2:0]     state_r;
  logic [2:0]     state_nxt;
  logic [2:0]     tap_r;
  logic [2:0]     tap_nxt;
  logic [DCW-1:0] dig_r;
  logic [DCW-1:0] dig_nxt;
  logic           dig_last;
  logic           in_acc;
  logic           load;

  // Captured samples and filter history.
  logic signed [SAMPLE_BITS-1:0] x_l_r;
  logic signed [SAMPLE_BITS-1:0] x_r_r;
  logic signed [SAMPLE_BITS-1:0] l_in_d1_r;
  logic signed [SAMPLE_BITS-1:0] l_in_d2_r;
  logic signed [FB_BITS-1:0]     l_fb_d1_r;
  logic signed [FB_BITS-1:0]     l_fb_d2_r;
  logic signed [SAMPLE_BITS-1:0] r_in_d1_r;
  logic signed [SAMPLE_BITS-1:0] r_in_d2_r;
  logic signed [FB_BITS-1:0]     r_fb_d1_r;
  logic signed [FB_BITS-1:0]     r_fb_d2_r;

  // Filter results and output register.
  logic signed [FB_BITS-1:0]     yl_r;
  logic signed [FB_BITS-1:0]     yr_r;
  logic signed [FB_BITS-1:0]     yl_nxt;
  logic signed [FB_BITS-1:0]     yr_nxt;
  logic signed [SAMPLE_BITS-1:0] gres_r;
  logic signed [SAMPLE_BITS-1:0] gres_nxt;
  logic signed [SAMPLE_BITS-1:0] yl_sb;
  logic signed [SAMPLE_BITS-1:0] yr_sb;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r;
  logic signed [SAMPLE_BITS-1:0] out_right_r;

  // Lane operands.
  mac_ctl_t              ctl_l;
  mac_ctl_t              ctl_r;
  logic signed [PARW-1:0] par_c;
  logic signed [PARW-1:0] par_l;
  logic [OPW-1:0]         opnd_l;
  logic [OPW-1:0]         opnd_r;
  logic signed [ACW-1:0]  acc_l;
  logic signed [ACW-1:0]  acc_r;
  logic signed [ACW-1:0]  tl;
  logic signed [ACW-1:0]  tr;
  logic signed [ACW-1:0]  tg;
  logic signed [ACW-1:0]  ql;
  logic signed [ACW-1:0]  qr;
  logic signed [ACW-1:0]  qg;

  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign load     = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign dig_last = (dig_r == DCW'(ND - 1));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r   <= CW'(1) << COEF_FRAC_BITS;
      coef_b1_r   <= '0;
      coef_b2_r   <= '0;
      coef_a1_r   <= '0;
      coef_a2_r   <= '0;
      clip_gain_r <= GAIN_BITS'(1) << GAIN_FRAC_BITS;
      mono_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COEF_B0:   coef_b0_r   <= CW'($signed(cfg_data));
        CFG_COEF_B1:   coef_b1_r   <= CW'($signed(cfg_data));
        CFG_COEF_B2:   coef_b2_r   <= CW'($signed(cfg_data));
        CFG_COEF_A1:   coef_a1_r   <= CW'($signed(cfg_data));
        CFG_COEF_A2:   coef_a2_r   <= CW'($signed(cfg_data));
        CFG_CLIP_GAIN: clip_gain_r <= cfg_data[GAIN_BITS-1:0];
        CFG_MONO_MODE: mono_r      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Tap selection: coefficient on the parallel side, sample on the serial side.
  always_comb begin
    par_c  = '0;
    opnd_l = '0;
    opnd_r = '0;
    case (tap_r)
      TAP_B0: begin
        par_c  = PARW'(coef_b0_r);
        opnd_l = OPW'(x_l_r);
        opnd_r = OPW'(x_r_r);
      end
      TAP_B1: begin
        par_c  = PARW'(coef_b1_r);
        opnd_l = OPW'(l_in_d1_r);
        opnd_r = OPW'(r_in_d1_r);
      end
      TAP_B2: begin
        par_c  = PARW'(coef_b2_r);
        opnd_l = OPW'(l_in_d2_r);
        opnd_r = OPW'(r_in_d2_r);
      end
      TAP_A1: begin
        par_c  = PARW'(coef_a1_r);
        opnd_l = OPW'(l_fb_d1_r);
        opnd_r = OPW'(r_fb_d1_r);
      end
      TAP_A2: begin
        par_c  = PARW'(coef_a2_r);
        opnd_l = OPW'(l_fb_d2_r);
        opnd_r = OPW'(r_fb_d2_r);
      end
      default: begin
      end
    endcase
    par_l = par_c;
    // In the gain pass the left lane multiplies the filter result by the gain.
    if (state_r == S_GAIN) begin
      par_l  = PARW'(yl_r);
      opnd_l = OPW'(clip_gain_r);
    end
  end

  // Lane control.
  always_comb begin
    ctl_l = '0;
    ctl_r = '0;
    case (state_r)
      S_MAC: begin
        ctl_l.step  = 1'b1;
        ctl_l.first = (dig_r == '0);
        ctl_l.last  = dig_last;
        ctl_l.sub   = (tap_r == TAP_A1) || (tap_r == TAP_A2);
        ctl_l.clr   = (dig_r == '0) && (tap_r == TAP_B0);
        ctl_r       = ctl_l;
      end
      S_GAIN: begin
        ctl_l.step  = 1'b1;
        ctl_l.first = (dig_r == '0);
        ctl_l.last  = dig_last;
        ctl_l.clr   = (dig_r == '0);
      end
      default: begin
      end
    endcase
  end

  sbsf_mac #(
    .PARW (PARW),
    .OPW  (OPW),
    .ACW  (ACW)
  ) u_mac_l (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_l),
    .par   (par_l),
    .opnd  (opnd_l),
    .acc   (acc_l)
  );

  sbsf_mac #(
    .PARW (PARW),
    .OPW  (OPW),
    .ACW  (ACW)
  ) u_mac_r (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_r),
    .par   (par_c),
    .opnd  (opnd_r),
    .acc   (acc_r)
  );

  // Round half up to whole samples, then clamp to the feedback range.
  always_comb begin
    tl = acc_l + HALF_C;
    tr = acc_r + HALF_C;
    ql = tl >>> COEF_FRAC_BITS;
    qr = tr >>> COEF_FRAC_BITS;
    if (ql > FB_HI) begin
      yl_nxt = FB_HI[FB_BITS-1:0];
    end else if (ql < FB_LO) begin
      yl_nxt = FB_LO[FB_BITS-1:0];
    end else begin
      yl_nxt = ql[FB_BITS-1:0];
    end
    if (qr > FB_HI) begin
      yr_nxt = FB_HI[FB_BITS-1:0];
    end else if (qr < FB_LO) begin
      yr_nxt = FB_LO[FB_BITS-1:0];
    end else begin
      yr_nxt = qr[FB_BITS-1:0];
    end
  end

  // Gain product: round off the gain fraction, clamp to the sample range.
  always_comb begin
    tg = acc_l + HALF_G;
    qg = tg >>> GAIN_FRAC_BITS;
    if (qg > SB_HI) begin
      gres_nxt = SB_HI[SAMPLE_BITS-1:0];
    end else if (qg < SB_LO) begin
      gres_nxt = SB_LO[SAMPLE_BITS-1:0];
    end else begin
      gres_nxt = qg[SAMPLE_BITS-1:0];
    end
  end

  // Stereo outputs clamp the filter results to the sample range.
  always_comb begin
    if (yl_r > SBF_HI) begin
      yl_sb = SBF_HI[SAMPLE_BITS-1:0];
    end else if (yl_r < SBF_LO) begin
      yl_sb = SBF_LO[SAMPLE_BITS-1:0];
    end else begin
      yl_sb = yl_r[SAMPLE_BITS-1:0];
    end
    if (yr_r > SBF_HI) begin
      yr_sb = SBF_HI[SAMPLE_BITS-1:0];
    end else if (yr_r < SBF_LO) begin
      yr_sb = SBF_LO[SAMPLE_BITS-1:0];
    end else begin
      yr_sb = yr_r[SAMPLE_BITS-1:0];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    dig_nxt   = dig_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MAC;
          tap_nxt   = TAP_B0;
          dig_nxt   = '0;
        end
      end
      S_MAC: begin
        if (dig_last) begin
          dig_nxt = '0;
          if (tap_r == TAP_A2) begin
            state_nxt = S_MFL;
          end else begin
            tap_nxt = tap_r + 3'd1;
          end
        end else begin
          dig_nxt = dig_r + DCW'(1);
        end
      end
      S_MFL: begin
        state_nxt = S_RND;
      end
      S_RND: begin
        dig_nxt   = '0;
        state_nxt = mono_r ? S_GAIN : S_DONE;
      end
      S_GAIN: begin
        if (dig_last) begin
          dig_nxt   = '0;
          state_nxt = S_GFL;
        end else begin
          dig_nxt = dig_r + DCW'(1);
        end
      end
      S_GFL: begin
        state_nxt = S_GRND;
      end
      S_GRND: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers and filter history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_r       <= TAP_B0;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
      l_in_d1_r   <= '0;
      l_in_d2_r   <= '0;
      l_fb_d1_r   <= '0;
      l_fb_d2_r   <= '0;
      r_in_d1_r   <= '0;
      r_in_d2_r   <= '0;
      r_fb_d1_r   <= '0;
      r_fb_d2_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      dig_r   <= dig_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        l_in_d2_r <= l_in_d1_r;
        l_in_d1_r <= x_l_r;
        l_fb_d2_r <= l_fb_d1_r;
        l_fb_d1_r <= yl_r;
        if (!mono_r) begin
          r_in_d2_r <= r_in_d1_r;
          r_in_d1_r <= x_r_r;
          r_fb_d2_r <= r_fb_d1_r;
          r_fb_d1_r <= yr_r;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_l_r <= in_left_sample;
      x_r_r <= in_right_sample;
    end
    if (state_r == S_RND) begin
      yl_r <= yl_nxt;
      yr_r <= yr_nxt;
    end
    if (state_r == S_GRND) begin
      gres_r <= gres_nxt;
    end
    if (load) begin
      out_left_r  <= mono_r ? gres_r : yl_sb;
      out_right_r <= mono_r ? gres_r : yr_sb;
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

endmodule

### sv/sbsf_mac.sv
module sbsf_mac import sbsf_pkg::*; #(
  parameter int PARW = 24,
  parameter int OPW  = 24,
  parameter int ACW  = 51
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mac_ctl_t               ctl,
  input  logic signed [PARW-1:0] par,
  input  logic [OPW-1:0]         opnd,
  output logic signed [ACW-1:0]  acc
);

  localparam int PRW = PARW + OPW;
  localparam int PPW = PARW + DIG_BITS + 1;

  logic [OPW-1:0]           sh_r;
  logic [OPW-1:0]           sh_nxt;
  logic [DIG_BITS-1:0]      dig;
  logic signed [DIG_BITS:0] dig_s;
  logic signed [PPW-1:0]    pp;
  logic signed [PRW-1:0]    prod_r;
  logic signed [PRW-1:0]    prod_nxt;
  logic                     done_r;
  logic                     sub_r;
  logic signed [ACW-1:0]    acc_r;
  logic signed [ACW-1:0]    acc_nxt;

  // Digit selection: the top digit comes straight from the operand, the rest
  // from the shift register, most significant first.
  always_comb begin
    dig    = ctl.first ? opnd[OPW-1 -: DIG_BITS] : sh_r[OPW-1 -: DIG_BITS];
    dig_s  = ctl.first ? {dig[DIG_BITS-1], dig} : {1'b0, dig};
    sh_nxt = (ctl.first ? opnd : sh_r) << DIG_BITS;
  end

  // Partial product and Horner-style product build-up.
  always_comb begin
    pp       = PPW'(par) * PPW'(dig_s);
    prod_nxt = ctl.first ? PRW'(pp) : (prod_r <<< DIG_BITS) + PRW'(pp);
  end

  // A finished product is folded into the accumulator in the cycle after its last step.
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (done_r) begin
      acc_nxt = sub_r ? acc_r - ACW'(prod_r) : acc_r + ACW'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= ctl.step & ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      sh_r   <= sh_nxt;
      prod_r <= prod_nxt;
      sub_r  <= ctl.sub;
    end
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

### tb/stereo_biquad_shelf_filter_top_tb.sv
module stereo_biquad_shelf_filter_top_tb import sbsf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 20;
  localparam int FB_BITS        = SAMPLE_BITS + HEADROOM_BITS;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;

  // Cycles to let pass after the last result before touching the registers.
  localparam int SETTLE_CYCLES  = 32;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int RANDOM_BLOCKS  = 9;
  localparam int BLOCK_PAIRS    = 100;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } sample_pair_t;

  typedef struct packed {
    logic         on;
    sample_pair_t value;
  } pinned_pair_t;

  typedef enum logic {ROW_PAIR, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [CFG_IDX_BITS-1:0]       idx;
    logic [CFG_DATA_BITS-1:0]      data;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          pinned;
    logic signed [SAMPLE_BITS-1:0] exp_left;
    logic signed [SAMPLE_BITS-1:0] exp_right;
  } dir_row_t;

  localparam int DIR_ROWS = 34;

  // Directed stimulus. Pinned rows carry a result that is obvious from the
  // current coefficients; all other rows are checked against the filter model.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sh7FFF, 16'sh8000,
      1'b1, 16'sh7FFF, 16'sh8000},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sh8000, 16'sh7FFF,
      1'b1, 16'sh8000, 16'sh7FFF},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sd0,    16'sd0,
      1'b1, 16'sd0,    16'sd0},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      -16'sd1,   16'sd1,
      1'b1, -16'sd1,   16'sd1},
    '{ROW_WRITE, CFG_COEF_B0,   24'h7FFFFF, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sh7FFF, 16'sh8000,
      1'b1, 16'sh7FFF, 16'sh8000},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sd1,    -16'sd1,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_WRITE, CFG_COEF_B0,   24'h800000, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sh7FFF, 16'sh8000,
      1'b1, 16'sh8000, 16'sh7FFF},
    '{ROW_WRITE, CFG_COEF_B1,   24'h7FFFFF, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_WRITE, CFG_COEF_B2,   24'h800000, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sd100,  -16'sd100,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sh8000, 16'sh7FFF,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_WRITE, CFG_COEF_A1,   24'h800000, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_WRITE, CFG_COEF_A2,   24'h7FFFFF, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sh7FFF, 16'sh7FFF,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sh7FFF, 16'sh7FFF,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sh8000, 16'sh8000,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_WRITE, CFG_MONO_MODE, 24'h000001, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_WRITE, CFG_CLIP_GAIN, 24'h000000, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sd1234, -16'sd777,
      1'b1, 16'sd0,    16'sd0},
    '{ROW_WRITE, CFG_CLIP_GAIN, 24'h00FFFF, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sh7FFF, 16'sd5,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_WRITE, CFG_UNUSED,    24'hFFFFFF, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      -16'sd5,   16'sd9,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_WRITE, CFG_COEF_B0,   24'h100000, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_WRITE, CFG_COEF_B1,   24'h000000, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_WRITE, CFG_COEF_B2,   24'h000000, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_WRITE, CFG_COEF_A1,   24'h000000, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_WRITE, CFG_COEF_A2,   24'h000000, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_WRITE, CFG_CLIP_GAIN, 24'h008000, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sd20000, 16'sd3,
      1'b1, 16'sd20000, 16'sd20000},
    '{ROW_WRITE, CFG_MONO_MODE, 24'h000000, 16'sd0,    16'sd0,
      1'b0, 16'sd0,    16'sd0},
    '{ROW_PAIR,  CFG_COEF_B0,   24'h0,      16'sd7,    -16'sd7,
      1'b1, 16'sd7,    -16'sd7}
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_left_sample = '0;
  logic signed [SAMPLE_BITS-1:0] in_right_sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_left_out;
  logic signed [SAMPLE_BITS-1:0] out_right_out;
  logic                          cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data = '0;

  // Shadow copy of the registers and of both channel histories.
  longint          coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [15:0]     clip_gain;
  logic            mono_mode;
  longint          in_d1 [2];
  longint          in_d2 [2];
  longint          fb_d1 [2];
  longint          fb_d2 [2];

  sample_pair_t    expected_pairs [$];
  pinned_pair_t    pinned_pairs [$];
  int              failures = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              calm_left = 0;
  int unsigned     cycle_count = 0;

  stereo_biquad_shelf_filter_top #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_left_sample (in_left_sample),
    .in_right_sample(in_right_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left_out   (out_left_out),
    .out_right_out  (out_right_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rounds v / 2^sh to the nearest integer, ties toward positive infinity.
  function automatic longint round_q(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint saturate(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One biquad section; the result is clamped to the feedback range before
  // it is stored in the history.
  function automatic longint run_section(input int ch, input longint x);
    longint acc;
    longint y;
    acc = coef_b0 * x + coef_b1 * in_d1[ch] + coef_b2 * in_d2[ch]
        - coef_a1 * fb_d1[ch] - coef_a2 * fb_d2[ch];
    y = saturate(round_q(acc, COEF_FRAC_BITS), FB_BITS);
    in_d2[ch] = in_d1[ch];
    in_d1[ch] = x;
    fb_d2[ch] = fb_d1[ch];
    fb_d1[ch] = y;
    return y;
  endfunction

  // Filters one stereo pair. In mono the right history is left alone.
  function automatic sample_pair_t filter_pair(input logic signed [SAMPLE_BITS-1:0] l,
                                               input logic signed [SAMPLE_BITS-1:0] r);
    sample_pair_t res;
    longint       yl;
    longint       ol;
    longint       orr;
    yl = run_section(0, longint'(l));
    if (mono_mode) begin
      ol  = saturate(round_q(yl * longint'(clip_gain), GAIN_FRAC_BITS), SAMPLE_BITS);
      orr = ol;
    end else begin
      ol  = saturate(yl, SAMPLE_BITS);
      orr = saturate(run_section(1, longint'(r)), SAMPLE_BITS);
    end
    res.left  = ol[SAMPLE_BITS-1:0];
    res.right = orr[SAMPLE_BITS-1:0];
    return res;
  endfunction

  // Receiver stalls, with occasional calm stretches where nobody idles.
  always @(negedge clk) begin
    if (calm_left > 0) begin
      calm_left <= calm_left - 1;
    end else if ($urandom_range(255) == 0) begin
      calm_left <= 40;
    end
    out_stall <= (calm_left == 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Watch both channels: predict on each input transaction, check each result.
  always @(posedge clk) begin : monitor
    sample_pair_t exp_pair;
    pinned_pair_t pin;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_pairs.size() == 0) begin
          $error("result transaction with no pending expectation");
          failures++;
        end else begin
          exp_pair = expected_pairs.pop_front();
          if (out_left_out !== exp_pair.left) begin
            $error("left_out mismatch: expected %0d, actual %0d",
                   exp_pair.left, out_left_out);
            failures++;
          end
          if (out_right_out !== exp_pair.right) begin
            $error("right_out mismatch: expected %0d, actual %0d",
                   exp_pair.right, out_right_out);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        exp_pair = filter_pair(in_left_sample, in_right_sample);
        pin = pinned_pairs.pop_front();
        if (pin.on) exp_pair = pin.value;
        expected_pairs.push_back(exp_pair);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // without touching in_valid, so the caller decides what follows.
  task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
                           input logic signed [SAMPLE_BITS-1:0] r,
                           input logic pinned,
                           input sample_pair_t pinned_value);
    pinned_pairs.push_back('{on: pinned, value: pinned_value});
    while (calm_left == 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_left_sample  <= l;
    in_right_sample <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop sending and wait until every result has come back and settled.
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write; the shadow copy follows at once since the block is idle.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_COEF_B0:   coef_b0 = longint'($signed(data));
      CFG_COEF_B1:   coef_b1 = longint'($signed(data));
      CFG_COEF_B2:   coef_b2 = longint'($signed(data));
      CFG_COEF_A1:   coef_a1 = longint'($signed(data));
      CFG_COEF_A2:   coef_a2 = longint'($signed(data));
      CFG_CLIP_GAIN: clip_gain = data[15:0];
      CFG_MONO_MODE: mono_mode = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Picks a new filter setting: a stable filter, fully random coefficients
  // or corner coefficients: the ends of their range, zero or unity.
  task automatic pick_setting;
    logic [CFG_DATA_BITS-1:0] coefs [5];
    logic [CFG_DATA_BITS-1:0] data;
    logic [CFG_DATA_BITS-1:0] corners [4];
    logic [15:0]              gain_corners [3];
    int                       kind;
    int                       a2;
    int                       lim;
    corners      = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'h100000};
    gain_corners = '{16'h0000, 16'h8000, 16'hFFFF};
    kind = $urandom_range(3);
    for (int i = 0; i < 5; i++) begin
      case (kind)
        2:       coefs[i] = CFG_DATA_BITS'($urandom());
        3:       coefs[i] = corners[$urandom_range(3)];
        default: coefs[i] = CFG_DATA_BITS'(int'($urandom_range(2097152)) - 1048576);
      endcase
    end
    if (kind < 2) begin
      a2  = int'($urandom_range(1887436)) - 943718;
      lim = ((1048576 + a2) / 100) * 95;
      coefs[3] = CFG_DATA_BITS'(int'($urandom_range(2 * lim)) - lim);
      coefs[4] = CFG_DATA_BITS'(a2);
    end
    write_reg(CFG_COEF_B0, coefs[0]);
    write_reg(CFG_COEF_B1, coefs[1]);
    write_reg(CFG_COEF_B2, coefs[2]);
    write_reg(CFG_COEF_A1, coefs[3]);
    write_reg(CFG_COEF_A2, coefs[4]);
    data = CFG_DATA_BITS'($urandom());
    if ($urandom_range(3) == 0) data[15:0] = gain_corners[$urandom_range(2)];
    write_reg(CFG_CLIP_GAIN, data);
    write_reg(CFG_MONO_MODE, CFG_DATA_BITS'($urandom()));
    write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom()));
  endtask

  // Main sequence: reset, directed table, then random blocks in three
  // idling phases with a fresh setting for each block.
  initial begin
    sample_pair_t pin_value;
    coef_b0   = longint'(1) <<< COEF_FRAC_BITS;
    coef_b1   = 0;
    coef_b2   = 0;
    coef_a1   = 0;
    coef_a2   = 0;
    clip_gain = 16'h8000;
    mono_mode = 1'b0;
    for (int ch = 0; ch < 2; ch++) begin
      in_d1[ch] = 0;
      in_d2[ch] = 0;
      fb_d1[ch] = 0;
      fb_d2[ch] = 0;
    end

    send_idle_pct = 27;
    recv_idle_pct = 63;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        pin_value.left  = dir_rows[i].exp_left;
        pin_value.right = dir_rows[i].exp_right;
        send_pair(dir_rows[i].left, dir_rows[i].right, dir_rows[i].pinned, pin_value);
      end
    end

    pin_value = '0;
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case (blk / 3)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain();
      pick_setting();
      for (int n = 0; n < BLOCK_PAIRS; n++) begin
        send_pair(SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()), 1'b0, pin_value);
      end
    end
    drain();

    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
